[rtl/four_level_page_table_walker_defines.svh]
// Assertion macros shared by the walker's checker.
// No dependencies; include by bare file name.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// same-cycle implication
`define PTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ptw_pkg.sv]
// Shared types, constants and helpers for the page-table walker.
// No dependencies; imported by every RTL file of the walker.
package ptw_pkg;

   localparam int TABLE_WORDS       = 4096;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int TABLE_COUNT       = TABLE_WORDS / ENTRIES_PER_TABLE;
   localparam int WORD_BITS         = $clog2(TABLE_WORDS);
   localparam int TBL_W             = (WORD_BITS > 9) ? WORD_BITS - 9 : 1;
   localparam int ADDR_EXT_W        = 17;

   typedef logic [63:0]          word_type;
   typedef logic [WORD_BITS-1:0] waddr_type;
   typedef logic [TBL_W-1:0]     tbl_type;

   localparam word_type KERNEL_BASE_RESET = 64'hFFFF_8000_0000_0000;
   localparam word_type ALL_ONES          = '1;

   // operation codes
   localparam logic [1:0] OP_WRITE         = 2'd0;
   localparam logic [1:0] OP_TRANSLATE     = 2'd1;
   localparam logic [1:0] OP_MAKE_WRITABLE = 2'd2;

   // status codes
   localparam logic [1:0] ST_WALK    = 2'd0;
   localparam logic [1:0] ST_KERNEL  = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_OUTSIDE = 2'd3;

   // register indexes (paddr bit 3)
   localparam logic REG_ROOT  = 1'b0;
   localparam logic REG_KBASE = 1'b1;

   typedef struct packed {
      logic [2:0] root_table_page;
      logic       root_oob;
      word_type   dmap_base;
   } cfg_type;

   typedef struct packed {
      word_type diff;
      logic     borrow;
   } sub_res_type;

   function automatic logic [8:0] va_slice(input word_type va, input logic [1:0] level);
      logic [8:0] s;
      case (level)
         2'd0:    s = va[47:39];
         2'd1:    s = va[38:30];
         2'd2:    s = va[29:21];
         default: s = va[20:12];
      endcase
      return s;
   endfunction

   function automatic waddr_type make_addr(input tbl_type tbl, input logic [8:0] idx);
      logic [TBL_W+8:0] wide;
      wide = {tbl, idx};
      return wide[WORD_BITS-1:0];
   endfunction

endpackage

[rtl/ptw_if.sv]
// Valid/ready channel interfaces for walker requests and responses.
// Depends on ptw_pkg.
interface ptw_req_if import ptw_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [11:0] word_index;
   word_type    entry_data;
   word_type    virtual_address;

   modport source (output valid, operation, word_index, entry_data, virtual_address,
                   input ready);
   modport sink   (input valid, operation, word_index, entry_data, virtual_address,
                   output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
   logic       valid;
   logic       ready;
   word_type   physical_address;
   logic [1:0] status;

   modport source (output valid, physical_address, status, input ready);
   modport sink   (input valid, physical_address, status, output ready);
endinterface

[rtl/ptw_store.sv]
// Table word store: one write port, one registered read port.
// Depends on ptw_pkg. Contents are undefined until written.
module ptw_store import ptw_pkg::*; (
   input  logic      clock,
   input  logic      wr_en,
   input  waddr_type wr_addr,
   input  word_type  wr_data,
   input  logic      rd_en,
   input  waddr_type rd_addr,
   output word_type  rd_data
);

   word_type mem [TABLE_WORDS];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ptw_sub.sv]
// Shared 64-bit subtract/compare unit: kernel base check and table bound check.
// Depends on ptw_pkg.
module ptw_sub import ptw_pkg::*; (
   input  word_type    a,
   input  word_type    b,
   output sub_res_type res
);

   logic [64:0] full;

   assign full       = {1'b0, a} - {1'b0, b};
   assign res.diff   = full[63:0];
   assign res.borrow = full[64];   // set when a < b

endmodule

[rtl/ptw_csr.sv]
// APB-style configuration registers: root table page and kernel base.
// Depends on ptw_pkg.
module ptw_csr import ptw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       psel,
   input  logic       penable,
   input  logic       pwrite,
   input  logic [3:0] paddr,
   input  word_type   pwdata,
   output word_type   prdata,
   output logic       pready,
   output cfg_type    cfg
);

   logic [2:0] root_ff;
   logic [2:0] root_in;
   word_type   kbase_ff;
   word_type   kbase_in;
   logic       wr;
   word_type   root_wide;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;

   always_comb begin
      root_in  = root_ff;
      kbase_in = kbase_ff;
      if (wr) begin
         unique case (paddr[3])
            REG_ROOT:  root_in  = pwdata[2:0];
            REG_KBASE: kbase_in = pwdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= '0;
         kbase_ff <= KERNEL_BASE_RESET;
      end else begin
         root_ff  <= root_in;
         kbase_ff <= kbase_in;
      end
   end

   always_comb begin
      unique case (paddr[3])
         REG_ROOT:  prdata = {61'd0, root_ff};
         REG_KBASE: prdata = kbase_ff;
         default:   prdata = '0;
      endcase
   end

   assign root_wide           = {61'd0, root_ff};
   assign cfg.root_table_page = root_ff;
   assign cfg.root_oob        = (root_wide >= 64'(TABLE_COUNT));
   assign cfg.dmap_base       = kbase_ff;

endmodule

[rtl/four_level_page_table_walker.sv]
// Channel   Dir  Handshake       Beat
// req_bus   in   valid/ready     operation, word_index, entry_data, virtual_address
// rsp_bus   out  valid/ready     physical_address, status
// csr (APB) in   psel/penable    paddr, pwdata -> prdata; pready tied high
//
// Write and unused operations: accept, then the response state. Translate and
// make-writable: accept, a base compare, then table level reads in the entry state
// (up to four, the store's single registered read port), then the response state.
// One item at a time; req ready is high only while the sequencer is idle.
// A stalled response holds the sequencer in its final state. Reset is synchronous.
// Depends on ptw_pkg, ptw_if, ptw_store, ptw_sub, ptw_csr.
module four_level_page_table_walker import ptw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ptw_req_if.sink    req_bus,
   ptw_rsp_if.source  rsp_bus,
   input  logic       psel,
   input  logic       penable,
   input  logic       pwrite,
   input  logic [3:0] paddr,
   input  word_type   pwdata,
   output word_type   prdata,
   output logic       pready
);

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_ENTRY, S_FIN} state_type;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   word_type    va_ff, va_in;
   logic [1:0]  level_ff, level_in;
   waddr_type   cur_addr_ff, cur_addr_in;
   word_type    res_pa_ff, res_pa_in;
   logic [1:0]  res_st_ff, res_st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    rsp_pa_ff, rsp_pa_in;
   logic [1:0]  rsp_st_ff, rsp_st_in;

   cfg_type     cfg;
   sub_res_type sub_res;
   word_type    sub_a, sub_b;
   logic        accept;
   logic        wr_en, rd_en;
   waddr_type   wr_addr, rd_addr;
   word_type    wr_data, entry;
   logic [ADDR_EXT_W-1:0] widx_ext;
   word_type    root_wide;

   ptw_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .cfg (cfg)
   );

   ptw_sub u_sub (.a(sub_a), .b(sub_b), .res(sub_res));

   ptw_store u_store (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_en, .rd_addr, .rd_data(entry)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign widx_ext      = ADDR_EXT_W'(req_bus.word_index);
   assign root_wide     = {61'd0, cfg.root_table_page};

   // shared unit: kernel compare in S_CHECK, next-table bound check otherwise
   assign sub_a = (state_ff == S_CHECK) ? va_ff : {12'd0, entry[63:12]};
   assign sub_b = (state_ff == S_CHECK) ? cfg.dmap_base : 64'(TABLE_COUNT);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      va_in        = va_ff;
      level_in     = level_ff;
      cur_addr_in  = cur_addr_ff;
      res_pa_in    = res_pa_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pa_in    = rsp_pa_ff;
      rsp_st_in    = rsp_st_ff;
      wr_en        = 1'b0;
      wr_addr      = widx_ext[WORD_BITS-1:0];
      wr_data      = req_bus.entry_data;
      rd_en        = 1'b0;
      rd_addr      = make_addr(root_wide[TBL_W-1:0], va_slice(va_ff, 2'd0));

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_bus.operation;
               va_in     = req_bus.virtual_address;
               res_pa_in = '0;
               res_st_in = ST_WALK;
               case (req_bus.operation) inside
                  OP_TRANSLATE, OP_MAKE_WRITABLE: state_in = S_CHECK;
                  OP_WRITE: begin
                     wr_en    = (widx_ext < ADDR_EXT_W'(TABLE_WORDS));
                     state_in = S_FIN;
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_CHECK: begin
            if (!sub_res.borrow) begin
               res_pa_in = sub_res.diff;
               res_st_in = ST_KERNEL;
               state_in  = S_FIN;
            end else if (cfg.root_oob) begin
               res_pa_in = ALL_ONES;
               res_st_in = ST_OUTSIDE;
               state_in  = S_FIN;
            end else begin
               rd_en       = 1'b1;
               cur_addr_in = rd_addr;
               level_in    = 2'd0;
               state_in    = S_ENTRY;
            end
         end
         S_ENTRY: begin
            if (!entry[0]) begin
               res_pa_in = ALL_ONES;
               res_st_in = ST_ABSENT;
               state_in  = S_FIN;
            end else if (level_ff == 2'd3) begin
               res_pa_in = {entry[63:12], va_ff[11:0]};
               res_st_in = ST_WALK;
               state_in  = S_FIN;
               if (op_ff == OP_MAKE_WRITABLE) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_addr_ff;
                  wr_data = entry | 64'd2;
               end
            end else if (!sub_res.borrow) begin
               // next table number beyond the store
               res_pa_in = ALL_ONES;
               res_st_in = ST_OUTSIDE;
               state_in  = S_FIN;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = make_addr(entry[12 +: TBL_W], va_slice(va_ff, level_ff + 2'd1));
               cur_addr_in = rd_addr;
               level_in    = level_ff + 2'd1;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pa_in    = res_pa_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      va_ff       <= va_in;
      level_ff    <= level_in;
      cur_addr_ff <= cur_addr_in;
      res_pa_ff   <= res_pa_in;
      res_st_ff   <= res_st_in;
      rsp_pa_ff   <= rsp_pa_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.physical_address = rsp_pa_ff;
   assign rsp_bus.status           = rsp_st_ff;

endmodule

[rtl/ptw_checker.sv]
// Port-level assertions for the page-table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker_defines.svh.
`include "four_level_page_table_walker_defines.svh"

module ptw_checker import ptw_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input word_type   rsp_pa,
   input logic [1:0] rsp_status
);

   // one item at a time: busy right after an accepted beat
   `PTW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted beat did not make the walker busy")

   // a response appears only after the sequencer was busy
   `PTW_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_valid), !$past(req_ready), "response rose without work in progress")

   // failed walks report an all-ones address
   `PTW_ASSERT_NOW(a_fail_all_ones, clock, reset, rsp_valid && (rsp_status == ST_ABSENT || rsp_status == ST_OUTSIDE), rsp_pa == ALL_ONES, "failed walk with address other than all ones")

   // stalled response beat holds
   `PTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pa) && $stable(rsp_status), "stalled response changed")

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_pa     (rsp_bus.physical_address),
   .rsp_status (rsp_bus.status)
);
